>>> hw/rtl/rdp_pkg.sv
package rdp_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int STEP_CMP_W  = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP          = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ORDER   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_OFFSET = 3'd6;

    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd512;
    localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd512;
    localparam logic [10:0] RST_WINDOW_LEFT   = 11'd4;
    localparam logic [10:0] RST_WINDOW_TOP    = 11'd4;
    localparam logic [3:0]  RST_STEP          = 4'd4;
    localparam logic        RST_COLOR_ORDER   = 1'b0;
    localparam logic        RST_SIGNED_OFFSET = 1'b1;

    localparam logic [23:0] OFFSET_MASK = 24'h808080;

    typedef struct packed {
        logic        clear;
        logic        keep;
        logic        frame_end;
        logic [23:0] trip;
    } cmd_t;

endpackage

>>> hw/rtl/rdp_front.sv
module rdp_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_STEP  = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [15:0]                    s_pixel,
    input  logic                           s_frame_start,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rdp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rdp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                           cmd_valid,
    output rdp_pkg::cmd_t                  cmd,
    input  logic                           cmd_ready
);

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = ($clog2(MAX_WIDTH) + 2 > 13) ? $clog2(MAX_WIDTH) + 2 : 13;
    localparam int PH_W  = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int SC_W  = rdp_pkg::STEP_CMP_W;

    logic [11:0]      frame_width_reg;
    logic [11:0]      frame_height_reg;
    logic [10:0]      window_left_reg;
    logic [10:0]      window_top_reg;
    logic [3:0]       step_reg;
    logic             color_order_reg;
    logic             signed_offset_reg;

    logic [CNT_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [PH_W-1:0]  cph_reg, cph_next, rph_reg, rph_next;

    logic [CNT_W-1:0] col_e, row_e;
    logic [PH_W-1:0]  cph_e, rph_e;
    logic [CMP_W-1:0] w_clamp, h_clamp;
    logic [SC_W-1:0]  st_clamp;
    logic             col_in, row_in, col_last, row_last, keep;
    logic [7:0]       red, green, blue;
    logic [23:0]      trip;
    logic             accept;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [11:0] v);
        logic [CMP_W-1:0] e;
        e = CMP_W'(v);
        if (e == '0) begin
            return CMP_W'(1);
        end else if (e > CMP_W'(MAX_WIDTH)) begin
            return CMP_W'(MAX_WIDTH);
        end
        return e;
    endfunction

    function automatic logic [PH_W-1:0] next_phase(input logic [PH_W-1:0] ph,
                                                  input logic [SC_W-1:0] lim);
        logic [SC_W-1:0] inc;
        inc = SC_W'(ph) + SC_W'(1);
        return (inc >= lim) ? '0 : PH_W'(inc);
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = cmd_ready;
    assign accept    = s_valid && s_ready;

    always_comb begin
        w_clamp = clamp_dim(frame_width_reg);
        h_clamp = clamp_dim(frame_height_reg);
        if (step_reg == '0) begin
            st_clamp = SC_W'(1);
        end else if (SC_W'(step_reg) > SC_W'(MAX_STEP)) begin
            st_clamp = SC_W'(MAX_STEP);
        end else begin
            st_clamp = SC_W'(step_reg);
        end

        col_e = s_frame_start ? '0 : col_reg;
        row_e = s_frame_start ? '0 : row_reg;
        cph_e = s_frame_start ? '0 : cph_reg;
        rph_e = s_frame_start ? '0 : rph_reg;

        col_in   = CMP_W'(col_e) >= CMP_W'(window_left_reg);
        row_in   = CMP_W'(row_e) >= CMP_W'(window_top_reg);
        col_last = CMP_W'(col_e) + CMP_W'(1) >= w_clamp;
        row_last = CMP_W'(row_e) + CMP_W'(1) >= h_clamp;
        keep     = row_in && (rph_e == '0) && col_in && (cph_e == '0);

        col_next = col_e;
        row_next = row_e;
        cph_next = cph_e;
        rph_next = rph_e;
        if (col_in) begin
            cph_next = next_phase(cph_e, st_clamp);
        end
        if (col_last) begin
            col_next = '0;
            cph_next = '0;
            if (row_in) begin
                rph_next = next_phase(rph_e, st_clamp);
            end
            if (row_last) begin
                row_next = '0;
                rph_next = '0;
            end else begin
                row_next = row_e + CNT_W'(1);
            end
        end else begin
            col_next = col_e + CNT_W'(1);
        end

        red   = {s_pixel[15:11], 3'b000};
        green = {s_pixel[10:5], 2'b00};
        blue  = {s_pixel[4:0], 3'b000};
        trip  = color_order_reg ? {red, green, blue} : {blue, green, red};
        if (signed_offset_reg) begin
            trip = trip ^ rdp_pkg::OFFSET_MASK;
        end

        cmd.clear     = s_frame_start;
        cmd.keep      = keep;
        cmd.frame_end = col_last && row_last;
        cmd.trip      = trip;
        cmd_valid     = s_valid && (keep || s_frame_start || (col_last && row_last));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= rdp_pkg::RST_FRAME_WIDTH;
            frame_height_reg  <= rdp_pkg::RST_FRAME_HEIGHT;
            window_left_reg   <= rdp_pkg::RST_WINDOW_LEFT;
            window_top_reg    <= rdp_pkg::RST_WINDOW_TOP;
            step_reg          <= rdp_pkg::RST_STEP;
            color_order_reg   <= rdp_pkg::RST_COLOR_ORDER;
            signed_offset_reg <= rdp_pkg::RST_SIGNED_OFFSET;
            col_reg           <= '0;
            row_reg           <= '0;
            cph_reg           <= '0;
            rph_reg           <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    rdp_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[11:0];
                    rdp_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[11:0];
                    rdp_pkg::REG_WINDOW_LEFT:   window_left_reg   <= cfg_data[10:0];
                    rdp_pkg::REG_WINDOW_TOP:    window_top_reg    <= cfg_data[10:0];
                    rdp_pkg::REG_STEP:          step_reg          <= cfg_data[3:0];
                    rdp_pkg::REG_COLOR_ORDER:   color_order_reg   <= cfg_data[0];
                    rdp_pkg::REG_SIGNED_OFFSET: signed_offset_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                cph_reg <= cph_next;
                rph_reg <= rph_next;
            end
        end
    end

endmodule

>>> hw/rtl/rdp_queue.sv
module rdp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rdp_pkg::cmd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rdp_pkg::cmd_t out_data
);

    localparam int DEPTH = rdp_pkg::QUEUE_DEPTH;
    localparam int PW    = rdp_pkg::QPTR_W;

    rdp_pkg::cmd_t  mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic           push, pop;

    assign in_ready  = count_reg != (PW+1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

>>> hw/rtl/rdp_back.sv
module rdp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rdp_pkg::cmd_t cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_packed_word,
    output logic          m_last
);

    logic [23:0] pend_bytes_reg, pend_bytes_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;
    logic        out_last_reg, out_last_next;
    logic        aux_valid_reg, aux_valid_next;
    logic [31:0] aux_word_reg, aux_word_next;

    logic [23:0] pb;
    logic [1:0]  pc;
    logic [55:0] acc;
    logic        full, fire, out_free;
    logic [23:0] nb;
    logic [1:0]  nc;
    logic [31:0] flush_word;

    assign m_valid       = out_valid_reg;
    assign m_packed_word = out_word_reg;
    assign m_last        = out_last_reg;
    assign out_free      = !out_valid_reg || m_ready;
    assign cmd_ready     = out_free && !aux_valid_reg;
    assign fire          = cmd_valid && cmd_ready;

    always_comb begin
        pb = cmd.clear ? '0 : pend_bytes_reg;
        pc = cmd.clear ? '0 : pend_cnt_reg;
        case (pc)
            2'd0:    acc = {32'h0, cmd.trip};
            2'd1:    acc = {24'h0, cmd.trip, pb[7:0]};
            2'd2:    acc = {16'h0, cmd.trip, pb[15:0]};
            default: acc = {8'h0, cmd.trip, pb};
        endcase
        full = cmd.keep && (pc != 2'd0);
        if (cmd.keep) begin
            if (full) begin
                nb = acc[55:32];
                nc = pc - 2'd1;
            end else begin
                nb = acc[23:0];
                nc = 2'd3;
            end
        end else begin
            nb = pb;
            nc = pc;
        end
        flush_word = (nc == 2'd0) ? 32'h0 : {8'h0, nb};

        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        aux_valid_next  = aux_valid_reg;
        aux_word_next   = aux_word_reg;

        if (out_free) begin
            out_valid_next = 1'b0;
            if (aux_valid_reg) begin
                out_valid_next = 1'b1;
                out_word_next  = aux_word_reg;
                out_last_next  = 1'b1;
                aux_valid_next = 1'b0;
            end else if (fire) begin
                out_valid_next = full || cmd.frame_end;
                out_word_next  = full ? acc[31:0] : flush_word;
                out_last_next  = cmd.frame_end && (!full || nc == 2'd0);
                aux_valid_next = full && cmd.frame_end && (nc != 2'd0);
                aux_word_next  = flush_word;
                pend_bytes_next = cmd.frame_end ? '0 : nb;
                pend_cnt_next   = cmd.frame_end ? '0 : nc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bytes_reg <= '0;
            pend_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            aux_valid_reg  <= 1'b0;
        end else begin
            pend_bytes_reg <= pend_bytes_next;
            pend_cnt_reg   <= pend_cnt_next;
            out_valid_reg  <= out_valid_next;
            aux_valid_reg  <= aux_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
        aux_word_reg <= aux_word_next;
    end

endmodule

>>> hw/rtl/rgb565_decimate_pack_rgb888_unit.sv
// An accepted pixel's command is queued, then registered into m_packed_word with m_valid.
// Throughput: one pixel per cycle while the command queue has room; the queue decouples
// pixel intake from the output register, which stalls only on m_ready.
// A frame end with a full word and a flush word parks the flush word and takes no command until it is sent.
// Reset (aresetn low, synchronous): registers return to defaults, counters,
// pending bytes, queue and output valid are cleared.
module rgb565_decimate_pack_rgb888_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_STEP  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [15:0]                     s_pixel,
    input  logic                            s_frame_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [31:0]                     m_packed_word,
    output logic                            m_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rdp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic          f_valid, f_ready;
    rdp_pkg::cmd_t f_cmd;
    logic          b_valid, b_ready;
    rdp_pkg::cmd_t b_cmd;

    rdp_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_STEP (MAX_STEP)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_frame_start(s_frame_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (f_valid),
        .cmd          (f_cmd),
        .cmd_ready    (f_ready)
    );

    rdp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (f_cmd),
        .out_valid(b_valid),
        .out_ready(b_ready),
        .out_data (b_cmd)
    );

    rdp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (b_valid),
        .cmd_ready    (b_ready),
        .cmd          (b_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_packed_word(m_packed_word),
        .m_last       (m_last)
    );

endmodule

>>> hw/rtl/rdp_checker.sv
module rdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_packed_word,
    input logic        m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_word) && $stable(m_last))
        else $error("output request changed while stalled");

    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_reset_in: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind rgb565_decimate_pack_rgb888_unit rdp_checker u_rdp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_packed_word(m_packed_word),
    .m_last       (m_last)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_WIDTH = 2048;
    localparam int MAX_STEP  = 8;

    localparam logic [rdp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } packed_result_t;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic [15:0]                     s_pixel       = '0;
    logic                            s_frame_start = 1'b0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic [31:0]                     m_packed_word;
    logic                            m_last;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [rdp_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [rdp_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    // register shadow
    logic [11:0] rf_width  = rdp_pkg::RST_FRAME_WIDTH;
    logic [11:0] rf_height = rdp_pkg::RST_FRAME_HEIGHT;
    logic [10:0] rf_left   = rdp_pkg::RST_WINDOW_LEFT;
    logic [10:0] rf_top    = rdp_pkg::RST_WINDOW_TOP;
    logic [3:0]  rf_step   = rdp_pkg::RST_STEP;
    logic        rf_order  = rdp_pkg::RST_COLOR_ORDER;
    logic        rf_offset = rdp_pkg::RST_SIGNED_OFFSET;

    // position and byte packer shadow
    logic [10:0] col_cnt    = '0;
    logic [10:0] row_cnt    = '0;
    logic [2:0]  col_ph     = '0;
    logic [2:0]  row_ph     = '0;
    logic [23:0] held_bytes = '0;
    logic [1:0]  held_cnt   = '0;

    packed_result_t expected_words[$];

    int errors        = 0;
    int pixels_sent   = 0;
    int words_checked = 0;
    int frames_closed = 0;
    int reg_writes    = 0;
    int send_idle_pct = 17;
    int recv_idle_pct = 69;
    int stall_token   = 0;
    int stall_seen    = 0;
    int stall_left    = 0;

    always #5 aclk = ~aclk;

    rgb565_decimate_pack_rgb888_unit #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_STEP (MAX_STEP)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_frame_start(s_frame_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_packed_word(m_packed_word),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [2:0] phase_after(input logic [2:0] ph, input int bound);
        return (int'(ph) + 1 >= bound) ? 3'd0 : ph + 3'd1;
    endfunction

    function automatic void predict_pixel(input logic [15:0] pix, input logic fs);
        int             w;
        int             h;
        int             st;
        int             total;
        int             n;
        logic [23:0]    trip;
        logic [63:0]    acc;
        packed_result_t res [2];
        w  = clamp_int(int'(rf_width), 1, MAX_WIDTH);
        h  = clamp_int(int'(rf_height), 1, MAX_WIDTH);
        st = clamp_int(int'(rf_step), 1, MAX_STEP);
        n  = 0;
        if (fs) begin
            col_cnt    = '0;
            row_cnt    = '0;
            col_ph     = '0;
            row_ph     = '0;
            held_bytes = '0;
            held_cnt   = '0;
        end
        if (row_cnt >= rf_top && row_ph == 0 && col_cnt >= rf_left && col_ph == 0) begin
            if (rf_order) begin
                trip = {pix[15:11], 3'b0, pix[10:5], 2'b0, pix[4:0], 3'b0};
            end else begin
                trip = {pix[4:0], 3'b0, pix[10:5], 2'b0, pix[15:11], 3'b0};
            end
            if (rf_offset) begin
                trip = trip ^ rdp_pkg::OFFSET_MASK;
            end
            acc   = {40'b0, held_bytes} | ({40'b0, trip} << (8 * held_cnt));
            total = int'(held_cnt) + 3;
            if (total >= 4) begin
                res[0].word = acc[31:0];
                res[0].last = 1'b0;
                n     = 1;
                acc   = acc >> 32;
                total = total - 4;
            end
            held_bytes = acc[23:0];
            held_cnt   = 2'(total);
        end
        if (col_cnt >= rf_left) begin
            col_ph = phase_after(col_ph, st);
        end
        if (int'(col_cnt) + 1 >= w) begin
            col_cnt = '0;
            col_ph  = '0;
            if (row_cnt >= rf_top) begin
                row_ph = phase_after(row_ph, st);
            end
            if (int'(row_cnt) + 1 >= h) begin
                row_cnt = '0;
                row_ph  = '0;
                // frame end: flush leftovers, else tag the last word, else send an empty one
                if (held_cnt != 0) begin
                    res[n].word = {8'b0, held_bytes};
                    res[n].last = 1'b1;
                    n++;
                end else if (n > 0) begin
                    res[n-1].last = 1'b1;
                end else begin
                    res[0].word = '0;
                    res[0].last = 1'b1;
                    n = 1;
                end
                held_bytes = '0;
                held_cnt   = '0;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
        for (int i = 0; i < n; i++) begin
            expected_words.push_back(res[i]);
        end
    endfunction

    // result check first, then the request accepted at this edge
    always @(posedge aclk) begin
        packed_result_t oldest;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                words_checked++;
                if (m_last) begin
                    frames_closed++;
                end
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: unexpected word %08h last %b", $realtime,
                                 m_packed_word, m_last);
                    end
                end else begin
                    oldest = expected_words.pop_front();
                    if (m_packed_word !== oldest.word || m_last !== oldest.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: word exp %08h got %08h, last exp %b got %b",
                                     $realtime, oldest.word, m_packed_word,
                                     oldest.last, m_last);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_pixel(s_pixel, s_frame_start);
                pixels_sent++;
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_pixel(input logic [15:0] pix, input logic fs);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_pixel       <= pix;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_frame(input int n_pix);
        for (int i = 0; i < n_pix; i++) begin
            send_pixel(16'($urandom), i == 0);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rdp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rdp_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rdp_pkg::REG_FRAME_WIDTH:   rf_width  = val;
            rdp_pkg::REG_FRAME_HEIGHT:  rf_height = val;
            rdp_pkg::REG_WINDOW_LEFT:   rf_left   = val[10:0];
            rdp_pkg::REG_WINDOW_TOP:    rf_top    = val[10:0];
            rdp_pkg::REG_STEP:          rf_step   = val[3:0];
            rdp_pkg::REG_COLOR_ORDER:   rf_order  = val[0];
            rdp_pkg::REG_SIGNED_OFFSET: rf_offset = val[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_frame(input logic [11:0] w, input logic [11:0] h,
                             input logic [11:0] left, input logic [11:0] top,
                             input logic [11:0] stp, input logic [11:0] order,
                             input logic [11:0] offset);
        write_reg(rdp_pkg::REG_FRAME_WIDTH, w);
        write_reg(rdp_pkg::REG_FRAME_HEIGHT, h);
        write_reg(rdp_pkg::REG_WINDOW_LEFT, left);
        write_reg(rdp_pkg::REG_WINDOW_TOP, top);
        write_reg(rdp_pkg::REG_STEP, stp);
        write_reg(rdp_pkg::REG_COLOR_ORDER, order);
        write_reg(rdp_pkg::REG_SIGNED_OFFSET, offset);
    endtask

    task automatic test_byte_order();
        set_frame(12'd4, 12'd1, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hF800, 1'b0);
        send_pixel(16'h07E0, 1'b0);
        drain();
        // 9 bytes: two full words, then a one-byte flush
        set_frame(12'd3, 12'd1, 12'd0, 12'd0, 12'd1, 12'd1, 12'd1);
        send_pixel(16'h001F, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        drain();
    endtask

    task automatic test_frame_restart();
        set_frame(12'd3, 12'd1, 12'd0, 12'd0, 12'd1, 12'd0, 12'd1);
        send_pixel(16'($urandom), 1'b1);
        send_pixel(16'($urandom), 1'b0);
        send_frame(3);
        drain();
    endtask

    task automatic test_empty_window();
        set_frame(12'd2, 12'd1, 12'd5, 12'd0, 12'd1, 12'd0, 12'd1);
        send_frame(2);
        drain();
    endtask

    task automatic test_register_limits();
        write_reg(REG_UNUSED, 12'hFFF);
        set_frame(12'd9, 12'd0, 12'd0, 12'd0, 12'd15, 12'd1, 12'd0);
        send_frame(9);
        drain();
    endtask

    task automatic test_live_reconfig();
        set_frame(12'd8, 12'hFFF, 12'd1, 12'd0, 12'd4, 12'd0, 12'd0);
        send_frame(4);
        drain();
        // column and phase now beyond the new limits
        write_reg(rdp_pkg::REG_FRAME_WIDTH, 12'd3);
        write_reg(rdp_pkg::REG_STEP, 12'd2);
        write_reg(rdp_pkg::REG_FRAME_HEIGHT, 12'd2);
        repeat (4) send_pixel(16'($urandom), 1'b0);
        drain();
    endtask

    task automatic test_widest_row();
        int saved_send;
        int saved_recv;
        saved_send    = send_idle_pct;
        saved_recv    = recv_idle_pct;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_frame(12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd8, 12'd1, 12'd1);
        send_frame(200);
        drain();
        send_idle_pct = saved_send;
        recv_idle_pct = saved_recv;
    endtask

    task automatic test_random_frames(input int sender_pct, input int receiver_pct,
                                      input int n_items, input bit long_stall);
        int target;
        int wf;
        int hf;
        int w_reg;
        int h_reg;
        int stp;
        int left;
        int top;
        int kind;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        target        = pixels_sent + n_items;
        if (long_stall) begin
            set_frame(12'd12, 12'd4, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0);
            stall_token <= stall_token + 1;
            send_frame(48);
            drain();
        end
        while (pixels_sent < target) begin
            w_reg = $urandom_range(0, 12);
            h_reg = $urandom_range(0, 5);
            wf    = (w_reg == 0) ? 1 : w_reg;
            hf    = (h_reg == 0) ? 1 : h_reg;
            stp   = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(0, 15);
            left  = ($urandom_range(99) < 90) ? $urandom_range(0, 3) : $urandom_range(0, 2047);
            top   = ($urandom_range(99) < 90) ? $urandom_range(0, 2) : $urandom_range(0, 2047);
            set_frame(12'(w_reg), 12'(h_reg),
                      {1'($urandom_range(0, 1)), 11'(left)},
                      {1'($urandom_range(0, 1)), 11'(top)},
                      {8'($urandom), 4'(stp)}, 12'($urandom), 12'($urandom));
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(99);
                if (kind < 75) begin
                    send_frame(wf * hf);
                end else if (kind < 90) begin
                    send_frame($urandom_range(1, wf * hf));
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        send_pixel(16'($urandom), 1'($urandom_range(0, 1)));
                    end
                end
            end
            drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_byte_order();
        test_frame_restart();
        test_empty_window();
        test_register_limits();
        test_live_reconfig();
        test_widest_row();
        test_random_frames(17, 69, 290, 1'b0);
        test_random_frames(69, 17, 290, 1'b0);
        test_random_frames(0, 0, 290, 1'b1);
        drain();
        repeat (20) @(posedge aclk);
        errors = errors + expected_words.size();
        $display("Sent %0d pixels, checked %0d words over %0d frame ends, %0d register writes",
                 pixels_sent, words_checked, frames_closed, reg_writes);
        $display("Covered byte orders, offset, windows, step and size limits, restarts, stalls");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rdp_pkg.sv
hw/rtl/rdp_front.sv
hw/rtl/rdp_queue.sv
hw/rtl/rdp_back.sv
hw/rtl/rgb565_decimate_pack_rgb888_unit.sv
hw/rtl/rdp_checker.sv
test/tb_top.sv
